// ===== src/fsba_pkg.sv =====
package fsba_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int OPCODE_W   = 1;
  localparam int INDEX_W    = 4;
  localparam int AMOUNT_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int REMAIN_W   = 16;
  localparam int STRAT_W    = 2;
  localparam int BIU_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [STRAT_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_NEXT  = 2'd2,
    FIT_WORST = 2'd3
  } fit_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_LOADED = 2'd0,
    STAT_ALLOC  = 2'd1,
    STAT_NONE   = 2'd2
  } status_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD = 1'b0,
    OP_REQ  = 1'b1
  } opcode_t;

endpackage

// ===== src/fsba_chan_if.sv =====
interface fsba_req_if;
  import fsba_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [INDEX_W-1:0]  block_index;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, opcode, block_index, amount, input ready);
  modport sink (input valid, opcode, block_index, amount, output ready);
endinterface

interface fsba_res_if;
  import fsba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  chosen_block;
  logic [REMAIN_W-1:0] remaining;

  modport source (output valid, status, chosen_block, remaining, input ready);
  modport sink (input valid, status, chosen_block, remaining, output ready);
endinterface

// ===== src/fsba_ram.sv =====
module fsba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fit_strategy_block_allocator.sv =====
// Channel  Dir  Payload                               Beat taken when
// -------  ---  ------------------------------------  ----------------------
// req      in   opcode, block_index, amount           req.valid && req.ready
// res      out  status, chosen_block, remaining       res.valid && res.ready
// cfg      in   cfg_index, cfg_data (strategy, blocks) cfg_we
//
// A load beat is written into the result register on acceptance; the next
// beat can be taken once the sequencer returns to ST_IDLE through ST_DONE.
// A request beat scans the m active blocks in ST_SCAN, where
// one shared capacity compare walks the table one block per cycle behind
// the registered RAM read and stops early on a hit for first and next fit;
// if a block fits, ST_WRITE then subtracts and writes back.
// Reset is synchronous; the valid bits make every entry read as zero.
// req.ready is high only while idle; a result held by a stalled res
// does not stop the next beat from being accepted, but a second finished
// result waits in ST_DONE until the output register frees.
module fit_strategy_block_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fsba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsba_pkg::CFG_DATA_W-1:0] cfg_data,
  fsba_req_if.sink                        req,
  fsba_res_if.source                      res
);
  import fsba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;
  localparam int LD_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Configuration registers
  fit_t             strategy;
  logic [BIU_W-1:0] blocks_in_use;

  // Sequencer
  state_t state, state_next;

  // Per-request context
  fit_t                 fit;
  logic [CNT_W-1:0]     active;
  logic [SIZE_BITS-1:0] need;

  // Issue side of the scan
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] issued;

  // Compare side of the scan, registered from the issue side
  logic             cmp_v;
  logic             cmp_last;
  logic [IDX_W-1:0] cmp_pos;
  logic             cmp_vld;

  // Best candidate so far
  logic                 found;
  logic [IDX_W-1:0]     best_pos;
  logic [SIZE_BITS-1:0] best_cap;

  logic [IDX_W-1:0]      rover;
  logic [MAX_BLOCKS-1:0] vld;

  // Pending result and output register
  status_t             res_status;
  logic [INDEX_W-1:0]  res_block;
  logic [REMAIN_W-1:0] res_rem;
  logic                out_valid;
  status_t             out_status;
  logic [INDEX_W-1:0]  out_block;
  logic [REMAIN_W-1:0] out_rem;

  // RAM port
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  // Combinational helpers
  logic                 accept;
  logic [CNT_W-1:0]     active_now;
  logic [SIZE_BITS-1:0] in_amt;
  logic                 load_hit;
  logic [IDX_W-1:0]     start_pos;
  logic [IDX_W-1:0]     pos_inc;
  logic                 issue_go;
  logic                 cmp_active;
  logic [SIZE_BITS-1:0] cmp_cap;
  logic                 cmp_fit;
  logic                 take;
  logic                 stop_early;
  logic                 scan_end;
  logic                 found_end;
  logic [SIZE_BITS-1:0] new_cap;
  logic                 out_free;

  fsba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_cap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  assign accept = req.valid && req.ready;

  // Clamp the searched range to the table size
  assign active_now = (CMP_W'(blocks_in_use) > CMP_W'(MAX_BLOCKS)) ?
                      CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_in_use);
  assign in_amt     = SIZE_BITS'(req.amount);
  assign load_hit   = LD_W'(req.block_index) < LD_W'(MAX_BLOCKS);

  // Next fit starts at the rover unless it lies outside the searched range
  assign start_pos = (strategy == FIT_NEXT && CNT_W'(rover) < active_now) ?
                     rover : '0;
  assign pos_inc   = (CNT_W'(pos) + CNT_W'(1) == active) ? '0 : pos + IDX_W'(1);
  assign issue_go  = (state == ST_SCAN) && (issued != active);

  assign cmp_active = cmp_v && (state == ST_SCAN);
  // Entries never written read as zero capacity
  assign cmp_cap    = cmp_vld ? ram_rdata : '0;
  assign cmp_fit    = cmp_cap >= need;
  // Strict compares keep ties on the lowest index
  assign take       = cmp_active && cmp_fit &&
                      (!found ||
                       (fit == FIT_BEST && cmp_cap < best_cap) ||
                       (fit == FIT_WORST && cmp_cap > best_cap));
  assign stop_early = cmp_active && cmp_fit && (fit inside {FIT_FIRST, FIT_NEXT});
  assign scan_end   = cmp_active && (stop_early || cmp_last);
  assign found_end  = found || (cmp_active && cmp_fit);
  assign new_cap    = best_cap - need;
  assign out_free   = !out_valid || res.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_t'(req.opcode) == OP_LOAD || active_now == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = found_end ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(req.block_index);
    ram_wdata = in_amt;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        // Ready is high throughout idle, so valid alone marks the beat
        ram_we    = req.valid && opcode_t'(req.opcode) == OP_LOAD && load_hit;
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = best_pos;
        ram_wdata = new_cap;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      strategy      <= FIT_FIRST;
      blocks_in_use <= BIU_RESET;
      rover         <= '0;
      vld           <= '0;
      out_valid     <= 1'b0;
      cmp_v         <= 1'b0;
      found         <= 1'b0;
      issued        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_STRATEGY: strategy <= fit_t'(cfg_data[STRAT_W-1:0]);
          REG_BLOCKS:   blocks_in_use <= cfg_data[BIU_W-1:0];
          default:      ;
        endcase
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      // Any load sends the rover home; a next-fit hit parks it on the pick
      if (accept && opcode_t'(req.opcode) == OP_LOAD) begin
        rover <= '0;
      end else if (state == ST_WRITE && fit == FIT_NEXT) begin
        rover <= best_pos;
      end
      cmp_v <= issue_go && !scan_end;
      if (accept) begin
        issued <= '0;
        found  <= 1'b0;
      end else begin
        if (issue_go) begin
          issued <= issued + CNT_W'(1);
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      fit    <= strategy;
      active <= active_now;
      need   <= in_amt;
      pos    <= start_pos;
      if (opcode_t'(req.opcode) == OP_LOAD) begin
        res_status <= STAT_LOADED;
        res_block  <= req.block_index;
        res_rem    <= load_hit ? REMAIN_W'(in_amt) : '0;
      end else begin
        res_status <= STAT_NONE;
        res_block  <= '0;
        res_rem    <= '0;
      end
    end else if (issue_go) begin
      pos <= pos_inc;
    end
    cmp_pos  <= pos;
    cmp_vld  <= vld[pos];
    cmp_last <= (issued == active - CNT_W'(1));
    if (take) begin
      best_pos <= cmp_pos;
      best_cap <= cmp_cap;
    end
    if (state == ST_WRITE) begin
      res_status <= STAT_ALLOC;
      res_block  <= INDEX_W'(best_pos);
      res_rem    <= REMAIN_W'(new_cap);
    end
    if (state == ST_DONE && out_free) begin
      out_status <= res_status;
      out_block  <= res_block;
      out_rem    <= res_rem;
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.chosen_block = out_block;
  assign res.remaining    = out_rem;

`ifndef SYNTH
  a_ram_write_phase : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE || state == ST_WRITE))
    else $error("capacity table written outside load or write-back");

  a_write_has_pick : assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> found)
    else $error("write-back without a chosen block");

  a_done_holds : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !res.ready) |=> (state == ST_DONE))
    else $error("pending result dropped while output stalled");

  a_rover_range : assert property (@(posedge clk) disable iff (rst)
    CNT_W'(rover) < CNT_W'(MAX_BLOCKS))
    else $error("rover beyond the table");
`endif

endmodule
